@@ hdl/wis_pkg.sv @@
package wis_pkg;

  // Store capacity and derived widths
  localparam int MAX_TASKS = 64;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int FILL_W    = IDX_W + 1;
  localparam logic [FILL_W-1:0] LINK_NONE = FILL_W'(MAX_TASKS);
  localparam logic [FILL_W-1:0] FILL_CAP  = FILL_W'(MAX_TASKS);

  typedef struct packed {
    logic [31:0] start_hour;
    logic [31:0] finish_hour;
    logic [31:0] gain;
    logic [5:0]  task_number;
    logic        final_task;
  } wis_in_t;

  typedef struct packed {
    logic [37:0] best_total;
    logic [5:0]  chosen_number;
    logic [6:0]  chosen_count;
    logic        end_of_list;
  } wis_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_TRACE_TOP,
    S_TRACE_HEAD,
    S_TRACE_READ,
    S_TRACE_EMIT
  } wis_state_t;

endpackage

@@ hdl/weighted_interval_scheduler.sv @@
// Weighted interval scheduler.
// Input channel: assert start with an item while busy is low; the item is
// taken at that clock edge. Items must arrive in non-decreasing finish_hour.
// Each stored item finds its latest compatible predecessor by a binary search
// over a row of deadline cells (one compare per cell, one search step per
// cycle, at most six steps), then updates the best-total memories in S_UPDATE.
// A stored non-final item keeps busy high through its search and update; a
// dropped non-final item leaves busy low. Items beyond MAX_TASKS are dropped;
// a dropped final item still ends the run.
// After an item with final_task set, the block walks the predecessor links and
// emits one result per chosen task, latest deadline first: it steps through
// S_TRACE_TOP and S_TRACE_HEAD, then alternates S_TRACE_READ and S_TRACE_EMIT,
// emitting in each S_TRACE_EMIT; end_of_list marks the last one.
// Each result is on the result port for one cycle, flagged by valid, and is
// taken at the edge ending that cycle; the receiver cannot stall. busy stays
// high until the last result is out, then a new run begins.
// rst (synchronous) empties the store and returns to idle.
module weighted_interval_scheduler import wis_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  wis_in_t  item,
  output logic     valid,
  output wis_out_t result
);

  wis_state_t state, state_next;

  wis_in_t           cur;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] below;
  logic [FILL_W-1:0] node;
  logic [FILL_W-1:0] k;
  logic [37:0]       total;
  logic [6:0]        total_cnt;

  // Memories
  logic [37:0]       best_mem [MAX_TASKS];
  logic [6:0]        cnt_mem  [MAX_TASKS];
  logic [IDX_W-1:0]  tail_mem [MAX_TASKS];
  logic [FILL_W-1:0] link_mem [MAX_TASKS];
  logic [5:0]        num_mem  [MAX_TASKS];

  logic [37:0]       best_a, best_b;
  logic [6:0]        cnt_a, cnt_b;
  logic [IDX_W-1:0]  tail_a, tail_b;
  logic [FILL_W-1:0] link_r;
  logic [5:0]        num_r;

  logic [IDX_W-1:0]  ra, rb, rn;
  logic              wr;
  logic              clr;
  logic              accept;

  // Cell row
  logic [MAX_TASKS-1:0] le;
  logic [MAX_TASKS:0]   tok;

  assign tok[0] = 1'b0;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    wis_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clr     (clr),
      .wr      (wr),
      .home    ((i == 0) ? 1'b1 : 1'b0),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .key     (cur.start_hour),
      .value   (cur.finish_hour),
      .le      (le[i])
    );
  end

  // Binary search over the cell compare results, one step per cycle
  logic [FILL_W-1:0] lo, hi, mid, lo_next, hi_next;
  always_comb begin
    mid     = FILL_W'(((FILL_W+1)'(lo) + (FILL_W+1)'(hi)) >> 1);
    lo_next = lo;
    hi_next = hi;
    if (lo < hi) begin
      if (le[mid[IDX_W-1:0]]) begin
        lo_next = mid + FILL_W'(1);
      end else begin
        hi_next = mid;
      end
    end
  end

  // Candidate and keep decision
  logic [37:0] cand;
  logic [6:0]  cand_cnt;
  logic [FILL_W-1:0] cand_link;
  logic        keep_prev;
  always_comb begin
    if (below != '0) begin
      cand      = 38'(cur.gain) + best_a;
      cand_cnt  = cnt_a + 7'd1;
      cand_link = FILL_W'(tail_a);
    end else begin
      cand      = 38'(cur.gain);
      cand_cnt  = 7'd1;
      cand_link = LINK_NONE;
    end
    keep_prev = (fill != '0) && (cand < best_b);
  end

  logic eol;
  assign eol = (link_r == LINK_NONE) || (k == FILL_W'(MAX_TASKS - 1));

  // Next state and control
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    valid      = 1'b0;
    wr         = 1'b0;
    clr        = 1'b0;
    accept     = 1'b0;
    ra         = below[IDX_W-1:0] - IDX_W'(1);
    rb         = fill[IDX_W-1:0] - IDX_W'(1);
    rn         = node[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          accept = 1'b1;
          if (fill < FILL_CAP) begin
            state_next = S_SEARCH;
          end else if (item.final_task) begin
            state_next = S_TRACE_TOP;
          end
        end
      end
      S_SEARCH: begin
        ra = lo_next[IDX_W-1:0] - IDX_W'(1);
        if (lo_next >= hi_next) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        wr         = 1'b1;
        state_next = cur.final_task ? S_TRACE_TOP : S_IDLE;
      end
      S_TRACE_TOP:  state_next = S_TRACE_HEAD;
      S_TRACE_HEAD: state_next = S_TRACE_READ;
      S_TRACE_READ: state_next = S_TRACE_EMIT;
      S_TRACE_EMIT: begin
        valid = 1'b1;
        if (eol) begin
          clr        = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_TRACE_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill level
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      fill <= '0;
    end else if (wr) begin
      fill <= fill + FILL_W'(1);
    end
  end

  // Hold transaction, search bounds and walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
      lo  <= '0;
      hi  <= fill;
    end
    if (state == S_SEARCH) begin
      lo    <= lo_next;
      hi    <= hi_next;
      below <= lo_next;
    end
    if (state == S_TRACE_HEAD) begin
      total     <= best_b;
      total_cnt <= cnt_b;
      node      <= FILL_W'(tail_b);
      k         <= '0;
    end
    if (state == S_TRACE_EMIT) begin
      node <= link_r;
      k    <= k + FILL_W'(1);
    end
  end

  // Write and read the memories
  always_ff @(posedge clk) begin
    if (wr) begin
      num_mem[fill[IDX_W-1:0]]  <= cur.task_number;
      link_mem[fill[IDX_W-1:0]] <= cand_link;
      if (keep_prev) begin
        best_mem[fill[IDX_W-1:0]] <= best_b;
        cnt_mem[fill[IDX_W-1:0]]  <= cnt_b;
        tail_mem[fill[IDX_W-1:0]] <= tail_b;
      end else begin
        best_mem[fill[IDX_W-1:0]] <= cand;
        cnt_mem[fill[IDX_W-1:0]]  <= cand_cnt;
        tail_mem[fill[IDX_W-1:0]] <= fill[IDX_W-1:0];
      end
    end
    best_a <= best_mem[ra];
    cnt_a  <= cnt_mem[ra];
    tail_a <= tail_mem[ra];
    best_b <= best_mem[rb];
    cnt_b  <= cnt_mem[rb];
    tail_b <= tail_mem[rb];
    link_r <= link_mem[rn];
    num_r  <= num_mem[rn];
  end

  // Drive the result port
  always_comb begin
    result.best_total    = total;
    result.chosen_number = num_r;
    result.chosen_count  = total_cnt;
    result.end_of_list   = eol;
  end

endmodule

@@ hdl/wis_cell.sv @@
module wis_cell import wis_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        clr,
  input  logic        wr,
  input  logic        home,
  input  logic        tok_in,
  output logic        tok_out,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        le
);

  logic        tok;
  logic [31:0] deadline;

  // Advance the write token one cell per stored transaction
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      tok <= home;
    end else if (wr) begin
      tok <= tok_in;
    end
  end

  // Hold the deadline of the entry this cell owns
  always_ff @(posedge clk) begin
    if (wr && tok) begin
      deadline <= value;
    end
  end

  assign tok_out = tok;
  assign le      = (deadline <= key);

endmodule

@@ verif/weighted_interval_scheduler_test.sv @@
`timescale 1ns / 1ps

module weighted_interval_scheduler_test import wis_pkg::*; ();

  // Scoreboard: holds a copy of the scheduling tables and the results still owed
  class schedule_board;
    logic [31:0] deadlines [64];
    logic [37:0] totals [64];
    logic [6:0]  sizes [64];
    logic [5:0]  tails [64];
    logic [6:0]  links [64];
    logic [5:0]  numbers [64];
    int          stored;
    wis_out_t    owed [$];
    int          errors;

    function new();
      stored = 0;
      errors = 0;
    endfunction

    // Count stored deadlines at or before the given hour
    function int boundary(int n, logic [31:0] hour);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (deadlines[mid] <= hour) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    // Note an accepted transaction and queue any results it causes
    function void note_task(wis_in_t t);
      int          below;
      int          i;
      int          node;
      int          k;
      logic [37:0] cand;
      logic [6:0]  cnt;
      logic [6:0]  link;
      wis_out_t    r;
      if (stored < MAX_TASKS) begin
        i = stored;
        below = boundary(i, t.start_hour);
        cand = 38'(t.gain);
        cnt = 7'd1;
        link = LINK_NONE;
        if (below > 0) begin
          cand = cand + totals[below - 1];
          cnt = cnt + sizes[below - 1];
          link = 7'(tails[below - 1]);
        end
        deadlines[i] = t.finish_hour;
        numbers[i] = t.task_number;
        links[i] = link;
        if (i > 0 && cand < totals[i - 1]) begin
          totals[i] = totals[i - 1];
          sizes[i] = sizes[i - 1];
          tails[i] = tails[i - 1];
        end else begin
          totals[i] = cand;
          sizes[i] = cnt;
          tails[i] = 6'(i);
        end
        stored++;
      end
      if (!t.final_task) return;
      node = tails[stored - 1];
      k = 0;
      while (node < MAX_TASKS && k < MAX_TASKS) begin
        r.best_total = totals[stored - 1];
        r.chosen_number = numbers[node];
        r.chosen_count = sizes[stored - 1];
        r.end_of_list = 1'b0;
        owed.push_back(r);
        k++;
        node = links[node];
      end
      if (k > 0) owed[owed.size() - 1].end_of_list = 1'b1;
      stored = 0;
    endfunction

    // Compare one result with the oldest one owed
    function void check_result(wis_out_t r);
      wis_out_t e;
      if (owed.size() == 0) begin
        $error("unexpected result %p", r);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (r.best_total !== e.best_total) begin
        $error("best_total expected %0d actual %0d", e.best_total, r.best_total);
        errors++;
      end
      if (r.chosen_number !== e.chosen_number) begin
        $error("chosen_number expected %0d actual %0d", e.chosen_number, r.chosen_number);
        errors++;
      end
      if (r.chosen_count !== e.chosen_count) begin
        $error("chosen_count expected %0d actual %0d", e.chosen_count, r.chosen_count);
        errors++;
      end
      if (r.end_of_list !== e.end_of_list) begin
        $error("end_of_list expected %0d actual %0d", e.end_of_list, r.end_of_list);
        errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  wis_in_t  item;
  logic     valid;
  wis_out_t result;

  schedule_board board;
  int          idle_pct;
  logic [31:0] last_finish;
  int          run_len;

  weighted_interval_scheduler DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .valid(valid), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every valid result at the clock edge
  always @(posedge clk) begin
    if (!rst && valid) board.check_result(result);
  end

  // Send one transaction, with random idle cycles first
  task automatic send_task(input wis_in_t t);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_task(t);
  endtask

  task automatic send_fields(input logic [31:0] s, input logic [31:0] f,
                             input logic [31:0] g, input logic [5:0] n, input logic fin);
    wis_in_t t;
    t.start_hour = s;
    t.finish_hour = f;
    t.gain = g;
    t.task_number = n;
    t.final_task = fin;
    send_task(t);
  endtask

  // Drop start, wait for every owed result, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // One random run of deadlines, sorted or not as asked, with random content
  task automatic random_run(input int len, input bit sorted);
    logic [31:0] f;
    logic [31:0] s;
    logic [31:0] g;
    int          span;
    f = $urandom_range(3) == 0 ? $urandom : $urandom_range(50);
    for (int i = 0; i < len; i++) begin
      span = $urandom_range(3);
      if (sorted) begin
        if (span == 0) f = f + $urandom_range(1);
        else if (span == 3 && f < 32'hF000_0000) f = f + $urandom_range(32'h0FFF_FFFF);
        else if (f < 32'hFFFF_FF00) f = f + $urandom_range(20);
      end else begin
        f = $urandom;
      end
      s = $urandom_range(2) == 0 ? $urandom : ((f > 30) ? f - $urandom_range(30) : 0);
      g = $urandom_range(3) == 0 ? $urandom : $urandom_range(1000);
      send_fields(s, f, g, 6'($urandom), i == len - 1);
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single task, extremes of every field
    send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b1);
    send_fields(0, 0, 0, 6'd0, 1'b1);
    // Start before any compatible task, deadline not after start, ties
    send_fields(0, 10, 5, 6'd1, 1'b0);
    send_fields(5, 10, 5, 6'd2, 1'b0);
    send_fields(10, 10, 5, 6'd3, 1'b0);
    send_fields(20, 15, 7, 6'd4, 1'b0);
    send_fields(15, 30, 32'hFFFF_FFFF, 6'd5, 1'b1);
    // Unsorted deadlines
    send_fields(3, 100, 9, 6'd10, 1'b0);
    send_fields(0, 5, 4, 6'd11, 1'b0);
    send_fields(50, 20, 8, 6'd12, 1'b0);
    send_fields(200, 1, 32'hAAAA_AAAA, 6'd13, 1'b1);
    drain();

    // Overflow: 70 tasks, final one dropped
    for (int i = 0; i < 70; i++)
      send_fields(32'(i), 32'(i + 1), 32'hFFFF_FFFF - 32'(i), 6'(i), i == 69);
    // Full store of disjoint tasks, wide totals and count of 64
    for (int i = 0; i < 64; i++)
      send_fields(32'(2 * i), 32'(2 * i), 32'hFFFF_FFFF, 6'(63 - i), i == 63);
    drain();

    // Random phases with varying idle levels; pause fully between some
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 80;
        2: idle_pct = 0;
        default: idle_pct = 25;
      endcase
      run_len = 0;
      while (run_len < 25) begin
        int len;
        len = $urandom_range(9) == 0 ? $urandom_range(64, 40) : $urandom_range(12, 1);
        random_run(len, $urandom_range(7) != 0);
        run_len += len;
        if ($urandom_range(3) == 0) drain();
      end
    end
    drain();
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
